// ----- hdl/swd_pkg.sv -----
`default_nettype none

package swd_pkg;

	// register file geometry
	localparam int NUM_DWELL = 5;
	localparam int DWELL_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int SPEED_W   = 3;

	typedef logic [DWELL_W-1:0]   dwell_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [SPEED_W-1:0]   speed_t;
	typedef logic [7:0]           byte_t;
	typedef logic [1:0]           phase_t;
	typedef logic [3:0]           coils_t;

	// configuration register indexes
	localparam cfg_idx_t REG_DWELL_0 = 3'd0;
	localparam cfg_idx_t REG_DWELL_4 = 3'd4;

	// item kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_CMD  = 1'b1;

	// command bytes
	localparam byte_t CMD_START   = 8'h73;
	localparam byte_t CMD_STOP    = 8'h66;
	localparam byte_t CMD_REVERSE = 8'h72;
	localparam byte_t CMD_FASTER  = 8'h2B;
	localparam byte_t CMD_SLOWER  = 8'h2D;
	localparam byte_t DIGIT_ZERO  = 8'h30;

	localparam speed_t TOP_SPEED = 3'd4;

	// dwell times after reset, slowest first
	localparam dwell_t DWELL_RESET [NUM_DWELL] = '{
		16'd2000, 16'd1000, 16'd500, 16'd300, 16'd100
	};

endpackage

`default_nettype wire

// ----- hdl/swd_ifs.sv -----
`default_nettype none

// command / tick channel
interface swd_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [7:0]  rx_byte;

	modport source (output valid, output cmd, output rx_byte, input ready);
	modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

// drive state and echo channel
interface swd_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  coils;
	logic        power_led;
	logic        reverse_led;
	logic        tx_valid;
	logic [7:0]  tx_byte;

	modport source (output valid, output coils, output power_led, output reverse_led,
		output tx_valid, output tx_byte, input ready);
	modport sink   (input valid, input coils, input power_led, input reverse_led,
		input tx_valid, input tx_byte, output ready);
endinterface

`default_nettype wire

// ----- hdl/swd_dwell_regs.sv -----
`default_nettype none

module swd_dwell_regs (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire swd_pkg::cfg_idx_t cfg_index,
	input  wire swd_pkg::dwell_t cfg_wdata,
	input  wire swd_pkg::speed_t speed,
	output swd_pkg::dwell_t      dwell
);
	import swd_pkg::*;

	dwell_t dwell_q [NUM_DWELL];
	speed_t lvl;

	// dwell register file, indexes beyond the last are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DWELL; i++) begin
				dwell_q[i] <= DWELL_RESET[i];
			end
		end else if (cfg_we && (cfg_index >= REG_DWELL_0) && (cfg_index <= REG_DWELL_4)) begin
			dwell_q[cfg_index] <= cfg_wdata;
		end
	end

	// level lookup, clamped to the top speed
	always_comb begin
		lvl   = (speed > TOP_SPEED) ? TOP_SPEED : speed;
		dwell = dwell_q[lvl];
	end

endmodule

`default_nettype wire

// ----- hdl/stepper_wave_drive_uart_control.sv -----
// channel   dir  payload                                       transfer
// cmd_ch    in   cmd[0], rx_byte[7:0]                          valid & ready
// res_ch    out  coils[3:0], power_led, reverse_led,           valid & ready
//                tx_valid, tx_byte[7:0]
// cfg       in   cfg_we, cfg_index[2:0], cfg_wdata[15:0]       cfg_we
//
// one item per cycle sustained while res_ch is not stalled; the result is registered behind the item register
// item register feeds the state update, which writes the result register
// result register stalls keep the item register; cmd_ch.ready drops only when both are full
// arst_n clears power, direction, speed, phase and loads the dwell defaults
`default_nettype none

module stepper_wave_drive_uart_control (
	input  wire logic              clk,
	input  wire logic              arst_n,
	swd_in_if.sink                 cmd_ch,
	swd_out_if.source              res_ch,
	input  wire logic              cfg_we,
	input  wire swd_pkg::cfg_idx_t cfg_index,
	input  wire swd_pkg::dwell_t   cfg_wdata
);
	import swd_pkg::*;

	// item register
	logic   valid_s1;
	logic   cmd_s1;
	byte_t  byte_s1;
	logic   advance;

	// controller state
	logic   power_q, rev_q, seq_active_q, seq_rev_q;
	speed_t speed_q;
	phase_t pos_q;
	dwell_t count_q, target_q;

	// next state
	logic   power_n, rev_n, seq_active_n, seq_rev_n;
	speed_t speed_n;
	phase_t pos_n;
	dwell_t count_n, target_n;
	dwell_t dwell_sel;
	dwell_t count_inc;
	logic   tx_valid_n;
	byte_t  tx_byte_n;
	coils_t coils_n;

	// result register
	logic   out_valid_q;
	coils_t coils_q;
	logic   power_led_q, reverse_led_q, tx_valid_q;
	byte_t  tx_byte_q;

	assign advance      = valid_s1 && (!out_valid_q || res_ch.ready);
	assign cmd_ch.ready = !valid_s1 || advance;

	// dwell lookup for the speed after this item
	swd_dwell_regs u_dwell (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.speed     (speed_n),
		.dwell     (dwell_sel)
	);

	// capture the transferred item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ch.ready) begin
			valid_s1 <= cmd_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ch.valid && cmd_ch.ready) begin
			cmd_s1  <= cmd_ch.cmd;
			byte_s1 <= cmd_ch.rx_byte;
		end
	end

	// command decode, dwell timing and phase sequencing
	always_comb begin
		power_n      = power_q;
		rev_n        = rev_q;
		speed_n      = speed_q;
		seq_active_n = seq_active_q;
		seq_rev_n    = seq_rev_q;
		pos_n        = pos_q;
		count_n      = count_q;
		target_n     = target_q;
		tx_valid_n   = 1'b0;
		tx_byte_n    = '0;
		count_inc    = count_q + 16'd1;

		if (cmd_s1 == KIND_TICK) begin
			// tick: count up the running phase toward its dwell target
			if (seq_active_q) begin
				count_n = count_inc;
				if (count_inc >= target_q) begin
					if (!power_q) begin
						seq_active_n = 1'b0;
					end else if (rev_q == seq_rev_q) begin
						pos_n    = pos_q + 2'd1;
						count_n  = '0;
						target_n = dwell_sel;
					end else begin
						seq_rev_n = rev_q;
						pos_n     = '0;
						count_n   = '0;
						target_n  = dwell_sel;
					end
				end
			end
		end else begin
			case (byte_s1)
				CMD_START: begin
					if (!power_q) begin
						power_n    = 1'b1;
						tx_valid_n = 1'b1;
						tx_byte_n  = DIGIT_ZERO + {5'b0, speed_q};
					end
				end
				CMD_STOP: begin
					if (power_q) begin
						power_n    = 1'b0;
						tx_valid_n = 1'b1;
						tx_byte_n  = CMD_STOP;
					end
				end
				CMD_REVERSE: begin
					if (power_q) begin
						rev_n = !rev_q;
					end
				end
				CMD_FASTER: begin
					if (power_q) begin
						speed_n    = (speed_q < TOP_SPEED) ? speed_q + 3'd1 : TOP_SPEED;
						tx_valid_n = 1'b1;
						tx_byte_n  = DIGIT_ZERO + {5'b0, speed_n};
					end
				end
				CMD_SLOWER: begin
					if (power_q) begin
						speed_n    = (speed_q != '0) ? speed_q - 3'd1 : speed_q;
						tx_valid_n = 1'b1;
						tx_byte_n  = DIGIT_ZERO + {5'b0, speed_n};
					end
				end
				default: begin
				end
			endcase
		end

		// powered with nothing running: start the first phase at once
		if (power_n && !seq_active_n) begin
			seq_active_n = 1'b1;
			seq_rev_n    = rev_n;
			pos_n        = '0;
			count_n      = '0;
			target_n     = dwell_sel;
		end

		// one-hot coil drive, reverse order mirrors the position
		coils_n = '0;
		if (seq_active_n) begin
			coils_n[seq_rev_n ? ~pos_n : pos_n] = 1'b1;
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q      <= 1'b0;
			rev_q        <= 1'b0;
			speed_q      <= '0;
			seq_active_q <= 1'b0;
			seq_rev_q    <= 1'b0;
			pos_q        <= '0;
			count_q      <= '0;
			target_q     <= '0;
		end else if (advance) begin
			power_q      <= power_n;
			rev_q        <= rev_n;
			speed_q      <= speed_n;
			seq_active_q <= seq_active_n;
			seq_rev_q    <= seq_rev_n;
			pos_q        <= pos_n;
			count_q      <= count_n;
			target_q     <= target_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			coils_q       <= coils_n;
			power_led_q   <= power_n;
			reverse_led_q <= power_n && rev_n;
			tx_valid_q    <= tx_valid_n;
			tx_byte_q     <= tx_byte_n;
		end
	end

	assign res_ch.valid       = out_valid_q;
	assign res_ch.coils       = coils_q;
	assign res_ch.power_led   = power_led_q;
	assign res_ch.reverse_led = reverse_led_q;
	assign res_ch.tx_valid    = tx_valid_q;
	assign res_ch.tx_byte     = tx_byte_q;

`ifndef ASSERT_OFF
	a_power_runs: assert property (@(posedge clk) disable iff (!arst_n)
		power_q |-> seq_active_q)
		else $error("powered with no phase running");

	a_dwell_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seq_active_q |-> (count_q <= target_q))
		else $error("dwell count passed its target");

	a_coils_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ($onehot(coils_q) == power_led_q || $onehot(coils_q)))
		else $error("coil drive not one-hot while powered");

	a_echo_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !tx_valid_q) |-> (tx_byte_q == '0))
		else $error("echo byte without echo");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("stalled item lost");
`endif

endmodule

`default_nettype wire
